>>> src/imu_offset_calibrate_and_scale_defines.svh
// assertion macros for the checker file of the imu calibration block
`ifndef IMU_OFFSET_CALIBRATE_AND_SCALE_DEFINES_SVH
`define IMU_OFFSET_CALIBRATE_AND_SCALE_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define IOCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds across reset
`define IOCS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/iocs_pkg.sv
// shared types, constants and codes of the imu offset calibration block
`default_nettype none

package iocs_pkg;

    // axes and accumulator sizes
    localparam int AXES      = 6;
    localparam int AXIS_W    = 3;
    localparam int SUM_W     = 24;
    localparam int QUOT_W    = 17;

    // serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = 5;

    // word queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_CALIB_SAMPLES  = 2'd0;
    localparam t_cfg_idx REG_GRAVITY_COUNTS = 2'd1;
    localparam t_cfg_idx REG_GYRO_GAIN      = 2'd2;

    localparam logic [7:0]  CALIB_SAMPLES_RST = 8'd20;
    localparam logic [14:0] GRAVITY_RST       = 15'd8192;
    localparam logic [17:0] GYRO_GAIN_RST     = 18'd71527;

    // temperature scale 256/132.48 in q16 and the 25 degree bias in q8
    localparam logic [17:0]        TEMP_K_Q16   = 18'd126640;
    localparam logic signed [17:0] TEMP_BIAS_Q8 = 18'sd6400;

    // z accel axis gets one g removed from its offset
    localparam logic [AXIS_W-1:0] AXIS_AZ   = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_LAST = 3'd5;

    // multiplier sequence in the back end
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] MUL_TEMP = 3'd0;
    localparam logic [STEP_W-1:0] MUL_GX   = 3'd1;
    localparam logic [STEP_W-1:0] MUL_GY   = 3'd2;
    localparam logic [STEP_W-1:0] MUL_GZ   = 3'd3;
    localparam logic [STEP_W-1:0] MUL_DONE = 3'd4;

    // what the back end has to do with a queued word
    typedef enum logic [1:0] {
        KIND_CALIB,
        KIND_CALIB_LAST,
        KIND_MEASURE
    } t_kind;

    // raw sample, temp in the lowest bits
    typedef struct packed {
        logic signed [15:0] gyro_z;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
        logic signed [15:0] temp;
    } t_sample;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] count;
        t_sample    sample;
    } t_entry;

    // result word, temp in the lowest bits
    typedef struct packed {
        logic signed [22:0] gyro_z;
        logic signed [22:0] gyro_y;
        logic signed [22:0] gyro_x;
        logic signed [16:0] accel_z;
        logic signed [16:0] accel_y;
        logic signed [16:0] accel_x;
        logic signed [17:0] temp;
    } t_result;

    typedef struct packed {
        logic [7:0]  calib_samples;
        logic [14:0] gravity;
        logic [17:0] gain;
    } t_cfg;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ACCUM,
        B_DIV_START,
        B_DIV_WAIT,
        B_DIFF,
        B_MUL,
        B_OUT
    } t_back_state;

endpackage

`default_nettype wire

>>> src/iocs_front.sv
// front end: accepts raw samples and tags them as calibration or measurement
`default_nettype none

module iocs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  iocs_pkg::t_sample i_sample,
    input  logic [7:0]       i_calib_samples,
    input  iocs_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output iocs_pkg::t_entry o_entry
);
    import iocs_pkg::*;

    logic       r_calibrated;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [7:0] w_target;
    logic       w_last;
    logic       w_accept;

    // handshake with the queue
    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && !i_q_stat.full;
    assign o_push   = w_accept;

    // a zero sample count acts as one
    assign n_count  = r_count + 8'd1;
    assign w_target = (i_calib_samples == 8'd0) ? 8'd1 : i_calib_samples;
    assign w_last   = (n_count >= w_target);

    // classify the word
    always_comb begin
        o_entry.sample = i_sample;
        o_entry.count  = n_count;
        if (r_calibrated) begin
            o_entry.kind = KIND_MEASURE;
        end else if (w_last) begin
            o_entry.kind = KIND_CALIB_LAST;
        end else begin
            o_entry.kind = KIND_CALIB;
        end
    end

    // calibration progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrated <= 1'b0;
            r_count      <= 8'd0;
        end else if (w_accept && !r_calibrated) begin
            r_count <= n_count;
            if (w_last) begin
                r_calibrated <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/iocs_fifo.sv
// short word queue between front end and back end
`default_nettype none

module iocs_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  iocs_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output iocs_pkg::t_q_stat o_stat,
    output iocs_pkg::t_entry  o_head
);
    import iocs_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_PTR_W:0]     r_fill;

    assign o_stat.full  = (r_fill == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_stat.valid = (r_fill != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level, depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (Q_PTR_W+1)'(1);
                2'b01:   r_fill <= r_fill - (Q_PTR_W+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/iocs_div.sv
// serial restoring divider: signed sum over sample count, truncated toward zero
`default_nettype none

module iocs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [iocs_pkg::SUM_W-1:0]  i_dividend,
    input  logic [7:0]                        i_divisor,
    output logic                              o_done,
    output logic signed [iocs_pkg::QUOT_W-1:0] o_quot
);
    import iocs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [7:0]           r_rem;
    logic [SUM_W-1:0]     r_q;
    logic [7:0]           r_div;
    logic                 r_neg;

    logic [8:0]           w_trial;
    logic [8:0]           w_sub;
    logic                 w_ge;
    logic [7:0]           n_rem;
    logic [QUOT_W-1:0]    w_mag;

    // one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_q[SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_sub   = w_trial - {1'b0, r_div};
        n_rem   = w_ge ? w_sub[7:0] : w_trial[7:0];
    end

    // the average never exceeds 2^15 in magnitude
    assign w_mag  = r_q[QUOT_W-1:0];
    assign o_quot = r_neg ? -$signed(w_mag) : $signed(w_mag);
    assign o_done = r_done;

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitude, remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_q   <= i_dividend[SUM_W-1] ? -i_dividend : i_dividend;
            r_rem <= 8'd0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[SUM_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

>>> src/iocs_back.sv
// back end: sums calibration samples, forms offsets, scales measurement words
`default_nettype none

module iocs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iocs_pkg::t_q_stat i_q_stat,
    input  iocs_pkg::t_entry  i_head,
    output logic              o_pop,
    input  iocs_pkg::t_cfg    i_cfg,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output iocs_pkg::t_result o_m_data
);
    import iocs_pkg::*;

    t_back_state              r_state;
    t_back_state              n_state;
    t_entry                   r_entry;
    logic signed [SUM_W-1:0]  r_sum  [AXES];
    logic signed [15:0]       r_off  [AXES];
    logic signed [16:0]       r_diff [AXES];
    logic [AXIS_W-1:0]        r_axis;
    logic [STEP_W-1:0]        r_step;
    logic signed [36:0]       r_prod;
    t_result                  r_res;
    t_result                  r_out;
    logic                     r_out_valid;

    logic signed [15:0]       w_axis [AXES];
    logic                     w_div_start;
    logic                     w_div_done;
    logic signed [QUOT_W-1:0] w_quot;
    logic signed [17:0]       w_off_wide;
    logic signed [15:0]       w_off_sat;
    logic signed [17:0]       w_mul_a;
    logic signed [18:0]       w_mul_b;
    logic signed [36:0]       w_prod;
    logic signed [36:0]       w_temp_sh;
    logic signed [36:0]       w_gyro_sh;
    logic                     w_load_out;

    // axis view of the word being worked on
    assign w_axis[0] = r_entry.sample.accel_x;
    assign w_axis[1] = r_entry.sample.accel_y;
    assign w_axis[2] = r_entry.sample.accel_z;
    assign w_axis[3] = r_entry.sample.gyro_x;
    assign w_axis[4] = r_entry.sample.gyro_y;
    assign w_axis[5] = r_entry.sample.gyro_z;

    iocs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum[r_axis]),
        .i_divisor  (r_entry.count),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // offset: average, one g off the z axis, saturated to 16 bits
    always_comb begin
        w_off_wide = {w_quot[QUOT_W-1], w_quot}
                   - ((r_axis == AXIS_AZ) ? {3'b000, i_cfg.gravity} : 18'd0);
        if (w_off_wide > 18'sd32767) begin
            w_off_sat = 16'sh7fff;
        end else if (w_off_wide < -18'sd32768) begin
            w_off_sat = -16'sh8000;
        end else begin
            w_off_sat = w_off_wide[15:0];
        end
    end

    // shared multiplier operands
    always_comb begin
        w_mul_b = {1'b0, i_cfg.gain};
        case (r_step)
            MUL_TEMP: begin
                w_mul_a = {{2{r_entry.sample.temp[15]}}, r_entry.sample.temp};
                w_mul_b = {1'b0, TEMP_K_Q16};
            end
            MUL_GX:  w_mul_a = {r_diff[3][16], r_diff[3]};
            MUL_GY:  w_mul_a = {r_diff[4][16], r_diff[4]};
            MUL_GZ:  w_mul_a = {r_diff[5][16], r_diff[5]};
            default: w_mul_a = 18'sd0;
        endcase
        w_prod    = w_mul_a * w_mul_b;
        w_temp_sh = (r_prod + 37'sd32768) >>> 16;
        w_gyro_sh = r_prod >>> 12;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_stat.valid) begin
                    o_pop   = 1'b1;
                    n_state = (i_head.kind == KIND_MEASURE) ? B_DIFF : B_ACCUM;
                end
            end
            B_ACCUM: begin
                n_state = (r_entry.kind == KIND_CALIB_LAST) ? B_DIV_START : B_IDLE;
            end
            B_DIV_START: begin
                w_div_start = 1'b1;
                n_state     = B_DIV_WAIT;
            end
            B_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_axis == AXIS_LAST) ? B_IDLE : B_DIV_START;
                end
            end
            B_DIFF: begin
                n_state = B_MUL;
            end
            B_MUL: begin
                if (r_step == MUL_DONE) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    w_load_out = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // control state and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_axis      <= '0;
            r_step      <= MUL_TEMP;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == B_ACCUM) begin
                r_axis <= '0;
                for (int i = 0; i < AXES; i++) begin
                    r_sum[i] <= r_sum[i] + {{(SUM_W-16){w_axis[i][15]}}, w_axis[i]};
                end
            end
            if (r_state == B_DIV_WAIT && w_div_done) begin
                r_axis <= r_axis + AXIS_W'(1);
            end
            if (r_state == B_DIFF) begin
                r_step <= MUL_TEMP;
            end else if (r_state == B_MUL) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_head;
        end
        if (r_state == B_DIV_WAIT && w_div_done) begin
            r_off[r_axis] <= w_off_sat;
        end
        if (r_state == B_DIFF) begin
            for (int i = 0; i < AXES; i++) begin
                r_diff[i] <= {w_axis[i][15], w_axis[i]} - {r_off[i][15], r_off[i]};
            end
        end
        if (r_state == B_MUL) begin
            if (r_step != MUL_DONE) begin
                r_prod <= w_prod;
            end
            // each later step stores what the previous step multiplied; the first stores the accel differences
            case (r_step)
                MUL_TEMP: begin
                    r_res.accel_x <= r_diff[0];
                    r_res.accel_y <= r_diff[1];
                    r_res.accel_z <= r_diff[2];
                end
                MUL_GX:   r_res.temp   <= w_temp_sh[17:0] + TEMP_BIAS_Q8;
                MUL_GY:   r_res.gyro_x <= w_gyro_sh[22:0];
                MUL_GZ:   r_res.gyro_y <= w_gyro_sh[22:0];
                MUL_DONE: r_res.gyro_z <= w_gyro_sh[22:0];
                default:  ;
            endcase
        end
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out;

endmodule

`default_nettype wire

>>> src/imu_offset_calibrate_and_scale.sv
// top level of the imu offset calibration and scaling block
//
//  channel   direction  ports                         payload
//  s         in         s_tvalid s_tready s_tdata     raw sample word, 112 bits
//  m         out        m_tvalid m_tready m_tdata     calibrated result word, 144 bits
//  cfg       in         i_cfg_we i_cfg_idx i_cfg_wdata register write, no read-back
//
//  a measurement word passes the back end in order: pop, offset subtract, the
//  steps on the one shared multiplier (temp and three gyro axes), output load.
//  a calibration word is popped and added to the sums; the last one then runs the
//  serial divider for each axis in turn, one quotient bit per cycle.
//  the two-word queue accepts while it has room; s_tready drops when it is full.
//  reset is synchronous and active low; it restores register defaults and
//  restarts calibration.
`default_nettype none

module imu_offset_calibrate_and_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // temp_raw, accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw,
    // gyro_z_raw
    input  logic [111:0]                        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // temp_q8, accel_x_cal, accel_y_cal, accel_z_cal, gyro_x_rads, gyro_y_rads,
    // gyro_z_rads, zero fill
    output logic [143:0]                        m_tdata,
    input  logic                                i_cfg_we,
    input  logic [iocs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [iocs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import iocs_pkg::*;

    t_cfg    r_cfg;
    t_entry  w_push_entry;
    t_entry  w_head;
    t_q_stat w_q_stat;
    t_result w_result;
    logic    w_push;
    logic    w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.calib_samples <= CALIB_SAMPLES_RST;
            r_cfg.gravity       <= GRAVITY_RST;
            r_cfg.gain          <= GYRO_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CALIB_SAMPLES:  r_cfg.calib_samples <= i_cfg_wdata[7:0];
                REG_GRAVITY_COUNTS: r_cfg.gravity       <= i_cfg_wdata[14:0];
                REG_GYRO_GAIN:      r_cfg.gain          <= i_cfg_wdata[17:0];
                default:            ;
            endcase
        end
    end

    iocs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_tvalid),
        .o_ready         (s_tready),
        .i_sample        (t_sample'(s_tdata)),
        .i_calib_samples (r_cfg.calib_samples),
        .i_q_stat        (w_q_stat),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    iocs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_head  (w_head)
    );

    iocs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_stat  (w_q_stat),
        .i_head    (w_head),
        .o_pop     (w_pop),
        .i_cfg     (r_cfg),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .o_m_data  (w_result)
    );

    assign m_tdata = {6'b000000, w_result};

endmodule

`default_nettype wire

>>> src/iocs_checker.sv
// port-level checks of the imu calibration block, bound to its top level
`default_nettype none
`include "imu_offset_calibrate_and_scale_defines.svh"

module iocs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);

    // a stalled result word stays offered
    `IOCS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")

    // a stalled result word does not change
    `IOCS_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result word changed while stalled")

    // reset empties the output register
    `IOCS_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_tvalid, "result offered right after reset")

    // temperature scaling keeps its field in range
    `IOCS_ASSERT(a_temp_range, m_tvalid |-> ($signed(m_tdata[17:0]) >= -32'sd56921) && ($signed(m_tdata[17:0]) <= 32'sd69719), "temperature out of range")

endmodule

bind imu_offset_calibrate_and_scale iocs_checker u_iocs_checker (.*);

`default_nettype wire
